>>> src/sct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sct_pkg;

   localparam int NUM_OPS = 46;
   localparam int NUM_KWS = 48;

   typedef enum logic [2:0] {
      CLS_INVALID = 3'd0,
      CLS_CHAR    = 3'd1,
      CLS_STRING  = 3'd2,
      CLS_OPER    = 3'd3,
      CLS_KEYWORD = 3'd4,
      CLS_IDENT   = 3'd5,
      CLS_INTEGER = 3'd6,
      CLS_END     = 3'd7
   } class_type;

   typedef enum logic [2:0] {
      M_START  = 3'd0,
      M_CHAR   = 3'd1,
      M_STRING = 3'd2,
      M_OP     = 3'd3,
      M_ALPHA  = 3'd4,
      M_NUM    = 3'd5,
      M_OCT    = 3'd6,
      M_HEX    = 3'd7
   } mode_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0] token_class;
      logic [9:0] token_length;
      logic [5:0] operator_index;
      logic [5:0] keyword_index;
      logic       last_of_run;
   } rsp_type;

   // operator text packed as three bytes, first character in the top byte
   function automatic logic [23:0] op_text(input logic [5:0] i);
      case (i)
         6'd0:  op_text = {"[", 16'h0};
         6'd1:  op_text = {"]", 16'h0};
         6'd2:  op_text = {"(", 16'h0};
         6'd3:  op_text = {")", 16'h0};
         6'd4:  op_text = {"{", 16'h0};
         6'd5:  op_text = {"}", 16'h0};
         6'd6:  op_text = {";", 16'h0};
         6'd7:  op_text = {".", 16'h0};
         6'd8:  op_text = {",", 16'h0};
         6'd9:  op_text = {"..", 8'h0};
         6'd10: op_text = "...";
         6'd11: op_text = {"++", 8'h0};
         6'd12: op_text = {"--", 8'h0};
         6'd13: op_text = {"&", 16'h0};
         6'd14: op_text = {"@", 16'h0};
         6'd15: op_text = {"*", 16'h0};
         6'd16: op_text = {"+", 16'h0};
         6'd17: op_text = {"-", 16'h0};
         6'd18: op_text = {"~", 16'h0};
         6'd19: op_text = {"!", 16'h0};
         6'd20: op_text = {"/", 16'h0};
         6'd21: op_text = {"%", 16'h0};
         6'd22: op_text = {"<<", 8'h0};
         6'd23: op_text = {">>", 8'h0};
         6'd24: op_text = {"<", 16'h0};
         6'd25: op_text = {">", 16'h0};
         6'd26: op_text = {"<=", 8'h0};
         6'd27: op_text = {">=", 8'h0};
         6'd28: op_text = {"==", 8'h0};
         6'd29: op_text = {"!=", 8'h0};
         6'd30: op_text = {"^", 16'h0};
         6'd31: op_text = {"|", 16'h0};
         6'd32: op_text = {"?", 16'h0};
         6'd33: op_text = {":", 16'h0};
         6'd34: op_text = {":=", 8'h0};
         6'd35: op_text = {"*=", 8'h0};
         6'd36: op_text = {"/=", 8'h0};
         6'd37: op_text = {"%=", 8'h0};
         6'd38: op_text = {"+=", 8'h0};
         6'd39: op_text = {"-=", 8'h0};
         6'd40: op_text = "<<=";
         6'd41: op_text = ">>=";
         6'd42: op_text = {"&=", 8'h0};
         6'd43: op_text = {"^=", 8'h0};
         6'd44: op_text = {"|=", 8'h0};
         6'd45: op_text = {"=", 16'h0};
         default: op_text = 24'h0;
      endcase
   endfunction

   // keyword text packed as eight bytes, first character in the top byte
   function automatic logic [63:0] kw_text(input logic [5:0] i);
      case (i)
         6'd0:  kw_text = {"def", 40'h0};
         6'd1:  kw_text = {"dec", 40'h0};
         6'd2:  kw_text = {"typ", 40'h0};
         6'd3:  kw_text = {"sub", 40'h0};
         6'd4:  kw_text = {"local", 24'h0};
         6'd5:  kw_text = {"as", 48'h0};
         6'd6:  kw_text = {"in", 48'h0};
         6'd7:  kw_text = {"code", 32'h0};
         6'd8:  kw_text = {"rodata", 16'h0};
         6'd9:  kw_text = {"data", 32'h0};
         6'd10: kw_text = {"bss", 40'h0};
         6'd11: kw_text = {"stack", 24'h0};
         6'd12: kw_text = "register";
         6'd13: kw_text = {"byte", 32'h0};
         6'd14: kw_text = {"twin", 32'h0};
         6'd15: kw_text = {"four", 32'h0};
         6'd16: kw_text = {"eigh", 32'h0};
         6'd17: kw_text = {"func", 32'h0};
         6'd18: kw_text = {"text", 32'h0};
         6'd19: kw_text = {"record", 16'h0};
         6'd20: kw_text = {"returns", 8'h0};
         6'd21: kw_text = {"begin", 24'h0};
         6'd22: kw_text = "assembly";
         6'd23: kw_text = {"sizeof", 16'h0};
         6'd24: kw_text = {"typeof", 16'h0};
         6'd25: kw_text = {"if", 48'h0};
         6'd26: kw_text = "unsigned";
         6'd27: kw_text = {"and", 40'h0};
         6'd28: kw_text = {"or", 48'h0};
         6'd29: kw_text = {"then", 32'h0};
         6'd30: kw_text = {"elsif", 24'h0};
         6'd31: kw_text = {"else", 32'h0};
         6'd32: kw_text = {"endif", 24'h0};
         6'd33: kw_text = {"case", 32'h0};
         6'd34: kw_text = {"when", 32'h0};
         6'd35: kw_text = {"others", 16'h0};
         6'd36: kw_text = {"esac", 32'h0};
         6'd37: kw_text = {"for", 40'h0};
         6'd38: kw_text = {"from", 32'h0};
         6'd39: kw_text = {"down", 32'h0};
         6'd40: kw_text = {"to", 48'h0};
         6'd41: kw_text = {"step", 32'h0};
         6'd42: kw_text = {"do", 48'h0};
         6'd43: kw_text = {"next", 32'h0};
         6'd44: kw_text = {"while", 24'h0};
         6'd45: kw_text = {"loop", 32'h0};
         6'd46: kw_text = {"return", 16'h0};
         6'd47: kw_text = {"end", 40'h0};
         default: kw_text = 64'h0;
      endcase
   endfunction

   function automatic logic [3:0] kw_len(input logic [63:0] t);
      logic [3:0] n;
      n = 4'd0;
      for (int j = 0; j < 8; j++) begin
         if (t[63-8*j -: 8] != 8'h0) n = 4'(j + 1);
      end
      return n;
   endfunction

   function automatic logic [1:0] op_len(input logic [23:0] t);
      logic [1:0] n;
      n = 2'd1;
      if (t[15:8] != 8'h0) n = 2'd2;
      if (t[7:0] != 8'h0) n = 2'd3;
      return n;
   endfunction

   // single-character operator, NUM_OPS when none
   function automatic logic [5:0] op_single(input logic [7:0] c);
      logic [5:0]  r;
      logic [23:0] t;
      r = 6'(NUM_OPS);
      for (int i = NUM_OPS - 1; i >= 0; i--) begin
         t = op_text(6'(i));
         if (op_len(t) == 2'd1 && t[23:16] == c && c != 8'h0)
            r = 6'(i);
      end
      return r;
   endfunction

   // extension of an operator by one character, NUM_OPS when none
   function automatic logic [5:0] op_extend(input logic [5:0] p, input logic [7:0] c);
      logic [23:0] t;
      logic [1:0]  l;
      logic [23:0] want;
      logic [5:0]  r;
      t = op_text(p);
      l = op_len(t);
      r = 6'(NUM_OPS);
      want = t;
      if (l == 2'd1) want[15:8] = c;
      else want[7:0] = c;
      if (c != 8'h0 && l != 2'd3 && p < 6'(NUM_OPS)) begin
         for (int i = NUM_OPS - 1; i >= 0; i--) begin
            if (op_text(6'(i)) == want && op_len(op_text(6'(i))) == l + 2'd1) r = 6'(i);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/sct_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sct_req_if;
   import sct_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sct_rsp_if;
   import sct_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/source_code_tokenizer.sv
// Source code tokenizer.
// req_ channel: one beat per source byte (char_code) or end-of-input mark.
// rsp_ channel: one beat per finished token (class, saturating length,
// operator index, keyword index, last_of_run).
// Each request beat yields zero, one or two tokens; a byte that ends a
// token and starts the next can give two, the second carrying last_of_run.
// The lexer state updates in the cycle the request is taken; its tokens go
// into a two-entry output buffer and appear on rsp_ from the next cycle.
// Throughput: one request per cycle while rsp_ready is high and each request
// yields at most one token; after two tokens, requests wait for one to drain.
// req_ready is high whenever the output buffer has room for two tokens,
// so a stalled receiver holds the buffer and in turn stalls requests.
// Reset (synchronous, active high) returns the lexer to between tokens and
// empties the output buffer.
// Keyword and operator matching is combinational against fixed tables in
// the package, so a request's tokens enter the buffer as the request is taken.
`timescale 1ns / 1ps
`default_nettype none
module source_code_tokenizer #(
   parameter int KEYWORD_CHARS = 8,
   parameter int LENGTH_MAX    = 1023
) (
   input  wire logic clock,
   input  wire logic reset,
   sct_req_if.sink   req,
   sct_rsp_if.source rsp
);
   import sct_pkg::*;

   localparam int LW = $clog2(LENGTH_MAX + 1);
   localparam int KW = $clog2(KEYWORD_CHARS);
   localparam logic [LW-1:0] LMAX = LW'(LENGTH_MAX);

   mode_type        mode_ff, mode_in;
   logic [LW-1:0]   len_ff, len_in;
   logic            esc_ff, esc_in, cesc_ff, cesc_in, zero_ff, zero_in;
   logic [5:0]      opp_ff, opp_in;
   logic [7:0]      word_ff [KEYWORD_CHARS];
   logic            wr_en;
   logic [KW-1:0]   wr_idx;

   rsp_type         buf_ff [2];
   logic [1:0]      cnt_ff;
   rsp_type         t0, t1;
   logic [1:0]      nt;

   logic            take, pop;
   logic [7:0]      c;
   logic            eof;

   assign c    = req.data.char_code;
   assign eof  = req.data.end_of_input;
   assign req.ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp.ready);
   assign take = req.valid && req.ready;
   assign pop  = rsp.valid && rsp.ready;
   assign rsp.valid = cnt_ff != 2'd0;
   assign rsp.data  = buf_ff[0];

   function automatic logic is_digit(input logic [7:0] x);
      return x >= "0" && x <= "9";
   endfunction
   function automatic logic is_letter(input logic [7:0] x);
      return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == "_";
   endfunction

   function automatic logic [9:0] len10(input logic [LW-1:0] v);
      logic [LW+9:0] w;
      w = {10'd0, v};
      return w[9:0];
   endfunction

   logic [LW-1:0] sat1;
   logic [5:0]    kw_idx;
   logic [5:0]    op_ext;
   logic [5:0]    op_one;

   assign sat1   = (len_ff < LMAX) ? len_ff + LW'(1) : LMAX;
   assign op_ext = eof ? 6'(NUM_OPS) : op_extend(opp_ff, c);
   assign op_one = op_single(c);

   always_comb begin
      logic [63:0] t;
      logic        hit;
      kw_idx = 6'(NUM_KWS);
      for (int i = NUM_KWS - 1; i >= 0; i--) begin
         t = kw_text(6'(i));
         hit = (len_ff != '0) && ({{(LW > 4 ? LW - 4 : 0){1'b0}}, kw_len(t)} == LW'(len_ff));
         for (int j = 0; j < 8; j++) begin
            if (j < KEYWORD_CHARS && 4'(j) < kw_len(t))
               if (word_ff[j] != t[63-8*j -: 8]) hit = 1'b0;
         end
         if (hit) kw_idx = 6'(i);
      end
   end

   function automatic rsp_type mk(input class_type cl, input logic [9:0] l,
                                  input logic [5:0] o, input logic [5:0] k);
      rsp_type r;
      r.token_class = cl;
      r.token_length = l;
      r.operator_index = o;
      r.keyword_index = k;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic push;
      logic [LW-1:0] cnt_up;
      mode_in = mode_ff;
      len_in  = len_ff;
      esc_in  = esc_ff;
      cesc_in = cesc_ff;
      zero_in = zero_ff;
      opp_in  = opp_ff;
      wr_en   = 1'b0;
      wr_idx  = len_ff[KW-1:0];
      t0 = mk(CLS_INVALID, 10'd0, 6'd0, 6'd0);
      t1 = t0;
      nt = 2'd0;
      push = 1'b0;
      cnt_up = (len_ff < LMAX) ? len_ff + LW'(1) : LMAX;
      case (mode_ff)
         M_CHAR: begin
            if ((len_ff == LW'(2) && !cesc_ff) || len_ff >= LW'(3)) begin
               if (eof || c != "'") begin
                  t0 = mk(CLS_INVALID, len10(len_ff), 6'd0, 6'd0); nt = 2'd1; push = 1'b1;
               end else begin
                  t0 = mk(CLS_CHAR, len10(sat1), 6'd0, 6'd0); nt = 2'd1;
                  mode_in = M_START;
               end
            end else if (eof) begin
               t0 = mk(CLS_INVALID, len10(len_ff), 6'd0, 6'd0); nt = 2'd1; push = 1'b1;
            end else begin
               if (len_ff == LW'(1)) cesc_in = c == "\\";
               len_in = cnt_up;
            end
         end
         M_STRING: begin
            if (!eof && c == "\"" && !esc_ff) begin
               t0 = mk(CLS_STRING, len10(sat1), 6'd0, 6'd0); nt = 2'd1;
               mode_in = M_START;
            end else if (eof || c == 8'h0a) begin
               t0 = mk(CLS_INVALID, len10(len_ff), 6'd0, 6'd0); nt = 2'd1; push = 1'b1;
            end else begin
               esc_in = esc_ff ? 1'b0 : (c == "\\");
               len_in = cnt_up;
            end
         end
         M_OP: begin
            if (op_ext < 6'(NUM_OPS)) begin
               opp_in = op_ext;
               len_in = cnt_up;
            end else begin
               t0 = mk(CLS_OPER, len10(len_ff), opp_ff, 6'd0); nt = 2'd1; push = 1'b1;
            end
         end
         M_ALPHA: begin
            if (!eof && (is_letter(c) || is_digit(c))) begin
               if (len_ff < LW'(KEYWORD_CHARS)) wr_en = 1'b1;
               len_in = cnt_up;
            end else begin
               if (len_ff <= LW'(KEYWORD_CHARS) && kw_idx < 6'(NUM_KWS))
                  t0 = mk(CLS_KEYWORD, len10(len_ff), 6'd0, kw_idx);
               else
                  t0 = mk(CLS_IDENT, len10(len_ff), 6'd0, 6'd0);
               nt = 2'd1; push = 1'b1;
            end
         end
         M_NUM: begin
            if (!eof && is_digit(c)) begin
               len_in = cnt_up;
            end else if (!eof && len_ff == LW'(1) && zero_ff && (c == "o" || c == "O")) begin
               mode_in = M_OCT; len_in = cnt_up;
            end else if (!eof && len_ff == LW'(1) && zero_ff && (c == "x" || c == "X")) begin
               mode_in = M_HEX; len_in = cnt_up;
            end else begin
               t0 = mk(CLS_INTEGER, len10(len_ff), 6'd0, 6'd0); nt = 2'd1; push = 1'b1;
            end
         end
         M_OCT, M_HEX: begin
            if (!eof && (mode_ff == M_OCT ? (c >= "0" && c <= "7")
                  : (is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")))) begin
               len_in = cnt_up;
            end else begin
               t0 = mk(len_ff > LW'(2) ? CLS_INTEGER : CLS_INVALID, len10(len_ff),
                       6'd0, 6'd0);
               nt = 2'd1; push = 1'b1;
            end
         end
         default: push = 1'b1;
      endcase

      // start of a token, either fresh or from a pushed-back byte, or the end token at end of input
      if (push) begin
         mode_in = M_START;
         if (eof) begin
            if (nt == 2'd0) t0 = mk(CLS_END, 10'd0, 6'd0, 6'd0);
            else t1 = mk(CLS_END, 10'd0, 6'd0, 6'd0);
            nt = nt + 2'd1;
         end else if (!(c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
            len_in  = LW'(1);
            esc_in  = 1'b0;
            cesc_in = 1'b0;
            zero_in = 1'b0;
            if (c == "'") mode_in = M_CHAR;
            else if (c == "\"") mode_in = M_STRING;
            else if (op_one < 6'(NUM_OPS)) begin
               opp_in = op_one; mode_in = M_OP;
            end else if (is_digit(c)) begin
               zero_in = c == "0"; mode_in = M_NUM;
            end else if (is_letter(c)) begin
               wr_en = 1'b1; wr_idx = '0; mode_in = M_ALPHA;
            end else begin
               if (nt == 2'd0) t0 = mk(CLS_INVALID, 10'd1, 6'd0, 6'd0);
               else t1 = mk(CLS_INVALID, 10'd1, 6'd0, 6'd0);
               nt = nt + 2'd1;
               len_in = '0;
            end
         end
      end
      if (nt == 2'd1) t0.last_of_run = 1'b1;
      if (nt == 2'd2) t1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_START;
         len_ff  <= '0;
         esc_ff  <= 1'b0;
         cesc_ff <= 1'b0;
         zero_ff <= 1'b0;
         opp_ff  <= 6'd0;
      end else if (take) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         esc_ff  <= esc_in;
         cesc_ff <= cesc_in;
         zero_ff <= zero_in;
         opp_ff  <= opp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && wr_en) word_ff[wr_idx] <= c;
   end

   // a request is only taken when the buffer is empty after this cycle's pop
   always_ff @(posedge clock) begin
      logic [1:0] base;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         base = cnt_ff - (pop ? 2'd1 : 2'd0);
         if (take && nt != 2'd0) begin
            buf_ff[0] <= t0;
            buf_ff[1] <= t1;
         end else if (pop) begin
            buf_ff[0] <= buf_ff[1];
         end
         cnt_ff <= base + (take ? nt : 2'd0);
      end
   end
endmodule
`default_nettype wire

>>> src/sct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sct_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_class,
   input wire logic [9:0] rsp_length,
   input wire logic [5:0] rsp_op,
   input wire logic [5:0] rsp_kw
);
   import sct_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_length))
      else $error("rsp beat dropped while stalled");

   a_end_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class == CLS_END |-> rsp_length == 10'd0)
      else $error("end token with length");

   a_op_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class == CLS_OPER |-> rsp_op < 6'(NUM_OPS))
      else $error("operator index out of range");

   a_kw_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_class == CLS_KEYWORD |-> rsp_kw < 6'(NUM_KWS) && rsp_length != 10'd0)
      else $error("bad keyword token");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");
endmodule

bind source_code_tokenizer sct_checker u_sct_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_class(rsp.data.token_class), .rsp_length(rsp.data.token_length),
   .rsp_op(rsp.data.operator_index), .rsp_kw(rsp.data.keyword_index)
);
`default_nettype wire
